// ----- hdl/qwsm_pkg.sv -----
// Shared widths, types and the quadrature step decode for the wheel speed block.
`default_nettype none
package qwsm_pkg;

    localparam int WINDOW_SIZE = 5;
    localparam int SPEED_BITS  = 12;
    localparam int COUNT_BITS  = 16;
    localparam int SMOOTH_BITS = 20;

    localparam int SLOT_W      = $clog2(WINDOW_SIZE);
    localparam int RANK_W      = $clog2(WINDOW_SIZE);
    localparam int MEDIAN_RANK = WINDOW_SIZE / 2;
    localparam int SUM_BITS    = SPEED_BITS + 1;
    // 230*128*sum needs SUM_BITS+15 bits, plus headroom for the old term and rounding
    localparam int ACC_W       = SPEED_BITS + 18;
    localparam int FRAC_BITS   = 8;

    typedef logic signed [SPEED_BITS-1:0]  speed_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic signed [SMOOTH_BITS-1:0] smooth_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [COUNT_BITS-1:0]         count_t;
    typedef logic [SLOT_W-1:0]             slot_t;
    typedef logic [RANK_W-1:0]             rank_t;
    typedef speed_t                        window_t [WINDOW_SIZE];

    typedef logic [1:0] step_t;
    localparam step_t STEP_NONE = 2'd0;
    localparam step_t STEP_FWD  = 2'd1;
    localparam step_t STEP_BWD  = 2'd2;

    typedef struct packed {
        logic  wr_en;
        slot_t wr_slot;
        logic  rank_en;
        logic  merge_en;
    } med_ctrl_t;

    // Forward order on {A,B}: 11 -> 01 -> 00 -> 10 -> 11
    function automatic step_t quad_step(logic [1:0] prev, logic [1:0] now);
        logic [1:0] fwd;
        logic [1:0] bwd;
        step_t      res;
        unique case (prev)
            2'd0:    begin fwd = 2'd2; bwd = 2'd1; end
            2'd1:    begin fwd = 2'd0; bwd = 2'd3; end
            2'd2:    begin fwd = 2'd3; bwd = 2'd0; end
            default: begin fwd = 2'd1; bwd = 2'd2; end
        endcase
        if (now == fwd)
            res = STEP_FWD;
        else if (now == bwd)
            res = STEP_BWD;
        else
            res = STEP_NONE;
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/quadrature_wheel_speed_median.sv -----
// Top level: two-wheel quadrature decode, median-of-window speeds and IIR mean.
//
// Sample channel (sample_valid/sample_ready) carries one clock sample of both
// wheels' A/B pins and a strobe. Samples without a strobe are taken every
// idle cycle and only advance the wheel counts; they produce no result.
// A sample with sample_strobe set closes the speed period: both speeds go
// into their windows and the filter sequencer runs rank, merge, multiply and
// output steps. sample_ready is low while the sequencer is in any of these
// steps, so no sample is taken until the output step completes.
// The result beat is registered onto result_valid in the output step once
// the result channel is free. If the receiver stalls, the result holds; the
// block keeps taking samples, and a following strobe waits in its output
// step until the held beat is taken.
// Reset clears counts, windows, the smoothed mean and result_valid; the block
// takes samples in the first cycle after reset.
`default_nettype none
module quadrature_wheel_speed_median
    import qwsm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic sample_valid,
    output logic      sample_ready,
    input  wire logic left_a,
    input  wire logic left_b,
    input  wire logic right_a,
    input  wire logic right_b,
    input  wire logic sample_strobe,
    output logic      result_valid,
    input  wire logic result_ready,
    output speed_t    left_speed_raw,
    output speed_t    right_speed_raw,
    output speed_t    left_median,
    output speed_t    right_median,
    output sum_t      speed_sum,
    output smooth_t   smoothed_speed
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RANK  = 3'd1;
    localparam logic [2:0] ST_MERGE = 3'd2;
    localparam logic [2:0] ST_MULT  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam acc_t K_OLD  = acc_t'(26);
    localparam acc_t K_NEW  = acc_t'(230 * 128);
    localparam acc_t K_HALF = acc_t'(128);
    localparam acc_t SM_HI  = {{(ACC_W-SMOOTH_BITS+1){1'b0}}, {(SMOOTH_BITS-1){1'b1}}};
    localparam acc_t SM_LO  = {{(ACC_W-SMOOTH_BITS+1){1'b1}}, {(SMOOTH_BITS-1){1'b0}}};

    logic [2:0] state_reg;
    logic [2:0] state_next;
    slot_t      slot_reg;
    logic       take;
    logic       close;
    logic       out_free;

    speed_t     left_period_speed;
    speed_t     right_period_speed;
    speed_t     left_med;
    speed_t     right_med;
    med_ctrl_t  med_ctrl;

    speed_t     left_raw_reg;
    speed_t     right_raw_reg;
    sum_t       sum_reg;
    sum_t       sum_next;
    acc_t       acc_reg;
    acc_t       acc_next;
    acc_t       quot;
    smooth_t    smooth_next;

    logic       result_valid_reg;
    speed_t     left_speed_raw_reg;
    speed_t     right_speed_raw_reg;
    speed_t     left_median_reg;
    speed_t     right_median_reg;
    sum_t       speed_sum_reg;
    smooth_t    smoothed_reg;

    assign sample_ready = (state_reg == ST_IDLE);
    assign take         = sample_valid && sample_ready;
    assign close        = take && sample_strobe;
    assign out_free     = !result_valid_reg || result_ready;

    qwsm_decoder u_left_dec (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .close  (close),
        .pin_a  (left_a),
        .pin_b  (left_b),
        .negate (1'b0),
        .speed  (left_period_speed)
    );

    qwsm_decoder u_right_dec (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .close  (close),
        .pin_a  (right_a),
        .pin_b  (right_b),
        .negate (1'b1),
        .speed  (right_period_speed)
    );

    assign med_ctrl.wr_en    = close;
    assign med_ctrl.wr_slot  = slot_reg;
    assign med_ctrl.rank_en  = (state_reg == ST_RANK);
    assign med_ctrl.merge_en = (state_reg == ST_MERGE);

    qwsm_median u_left_med (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (med_ctrl),
        .wr_data (left_period_speed),
        .median  (left_med)
    );

    qwsm_median u_right_med (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (med_ctrl),
        .wr_data (right_period_speed),
        .median  (right_med)
    );

    assign sum_next = sum_t'(left_med) + sum_t'(right_med);
    assign acc_next = acc_t'(smoothed_reg) * K_OLD + acc_t'(sum_next) * K_NEW + K_HALF;

    // Arithmetic shift gives the floor of the Q8 division
    assign quot = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (quot > SM_HI)
            smooth_next = SM_HI[SMOOTH_BITS-1:0];
        else if (quot < SM_LO)
            smooth_next = SM_LO[SMOOTH_BITS-1:0];
        else
            smooth_next = quot[SMOOTH_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (close) state_next = ST_RANK;
            ST_RANK:  state_next = ST_MERGE;
            ST_MERGE: state_next = ST_MULT;
            ST_MULT:  state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= '0;
            result_valid_reg <= 1'b0;
            smoothed_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (close)
            begin
                if (slot_reg == slot_t'(WINDOW_SIZE - 1))
                    slot_reg <= '0;
                else
                    slot_reg <= slot_reg + slot_t'(1);
            end
            if ((state_reg == ST_OUT) && out_free)
            begin
                result_valid_reg <= 1'b1;
                smoothed_reg     <= smooth_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
        begin
            left_raw_reg  <= left_period_speed;
            right_raw_reg <= right_period_speed;
        end
        if (state_reg == ST_MULT)
        begin
            sum_reg <= sum_next;
            acc_reg <= acc_next;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            left_speed_raw_reg  <= left_raw_reg;
            right_speed_raw_reg <= right_raw_reg;
            left_median_reg     <= left_med;
            right_median_reg    <= right_med;
            speed_sum_reg       <= sum_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign left_speed_raw  = left_speed_raw_reg;
    assign right_speed_raw = right_speed_raw_reg;
    assign left_median     = left_median_reg;
    assign right_median    = right_median_reg;
    assign speed_sum       = speed_sum_reg;
    assign smoothed_speed  = smoothed_reg;

endmodule
`default_nettype wire

// ----- hdl/qwsm_decoder.sv -----
// One wheel's quadrature decoder, count register and saturated period speed.
`default_nettype none
module qwsm_decoder
    import qwsm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   take,
    input  wire logic   close,
    input  wire logic   pin_a,
    input  wire logic   pin_b,
    input  wire logic   negate,
    output speed_t      speed
);

    localparam int EXT_W = COUNT_BITS + 1;
    localparam logic signed [EXT_W-1:0] SAT_HI =
        {{(EXT_W-SPEED_BITS+1){1'b0}}, {(SPEED_BITS-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO =
        {{(EXT_W-SPEED_BITS+1){1'b1}}, {(SPEED_BITS-1){1'b0}}};

    logic [1:0]              prev_pins_reg;
    count_t                  count_reg;
    count_t                  count_next;
    count_t                  mark_reg;
    count_t                  delta;
    logic signed [EXT_W-1:0] delta_ext;
    logic signed [EXT_W-1:0] delta_dir;
    logic [1:0]              pins;

    assign pins = {pin_a, pin_b};

    always_comb
    begin
        case (quad_step(prev_pins_reg, pins))
            STEP_FWD: count_next = count_reg + count_t'(1);
            STEP_BWD: count_next = count_reg - count_t'(1);
            default:  count_next = count_reg;
        endcase
    end

    assign delta     = count_next - mark_reg;
    assign delta_ext = $signed({delta[COUNT_BITS-1], delta});
    assign delta_dir = negate ? -delta_ext : delta_ext;

    always_comb
    begin
        if (delta_dir > SAT_HI)
            speed = SAT_HI[SPEED_BITS-1:0];
        else if (delta_dir < SAT_LO)
            speed = SAT_LO[SPEED_BITS-1:0];
        else
            speed = delta_dir[SPEED_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= 2'b00;
            count_reg     <= '0;
            mark_reg      <= '0;
        end
        else if (take)
        begin
            prev_pins_reg <= pins;
            count_reg     <= count_next;
            if (close)
                mark_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/qwsm_rank_lane.sv -----
// Rank of one window entry among all entries, ties broken by slot position.
`default_nettype none
module qwsm_rank_lane
    import qwsm_pkg::*;
(
    input  wire window_t window,
    input  wire slot_t   idx,
    output rank_t        rank
);

    speed_t own;

    assign own = window[idx];

    always_comb
    begin
        rank = '0;
        for (int j = 0; j < WINDOW_SIZE; j++)
        begin
            if (slot_t'(j) != idx)
            begin
                if ((window[j] < own) || ((window[j] == own) && (slot_t'(j) < idx)))
                    rank = rank + rank_t'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/qwsm_median.sv -----
// Speed window of one wheel with parallel rank lanes and a median merge stage.
`default_nettype none
module qwsm_median
    import qwsm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire med_ctrl_t ctrl,
    input  wire speed_t    wr_data,
    output speed_t         median
);

    window_t window_reg;
    rank_t   rank_lane [WINDOW_SIZE];
    rank_t   rank_reg  [WINDOW_SIZE];
    speed_t  median_reg;
    speed_t  median_next;

    for (genvar g = 0; g < WINDOW_SIZE; g++)
    begin : g_lane
        qwsm_rank_lane u_lane (
            .window (window_reg),
            .idx    (slot_t'(g)),
            .rank   (rank_lane[g])
        );
    end

    // Ranks are unique, so exactly one lane holds the middle rank
    always_comb
    begin
        median_next = window_reg[0];
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            if (rank_reg[i] == rank_t'(MEDIAN_RANK))
                median_next = window_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
                window_reg[i] <= '0;
        end
        else if (ctrl.wr_en)
        begin
            window_reg[ctrl.wr_slot] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rank_en)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
                rank_reg[i] <= rank_lane[i];
        end
        if (ctrl.merge_en)
            median_reg <= median_next;
    end

    assign median = median_reg;

endmodule
`default_nettype wire

// ----- hdl/qwsm_checker.sv -----
// Port-level checks on the wheel speed block, bound to its top level.
`default_nettype none
module qwsm_checker
    import qwsm_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    sample_valid,
    input wire logic    sample_ready,
    input wire logic    sample_strobe,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire speed_t  left_speed_raw,
    input wire speed_t  right_speed_raw,
    input wire speed_t  left_median,
    input wire speed_t  right_median,
    input wire sum_t    speed_sum,
    input wire smooth_t smoothed_speed
);

    // A stalled result beat holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(speed_sum) && $stable(smoothed_speed)
             && $stable(left_speed_raw) && $stable(right_speed_raw)))
        else $error("result beat changed while stalled");

    // On a valid result beat the sum field matches the two medians it is built from
    a_sum_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (speed_sum == (sum_t'(left_median) + sum_t'(right_median))))
        else $error("speed_sum differs from left_median + right_median");

    // A strobe beat starts the filter sequence and closes the sample channel
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready && sample_strobe) |=> !sample_ready)
        else $error("sample channel open right after a strobe beat");

    // A new result only comes out of the output step, never from idle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(sample_ready))
        else $error("result appeared without a filter sequence");

endmodule

bind quadrature_wheel_speed_median qwsm_checker u_qwsm_checker (.*);
`default_nettype wire
